// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/fcsc_pkg.sv =====
// types, codes and sizes shared by the filter clause syntax checker
package fcsc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] t_sym;
    localparam t_sym SYM_LEFT = 2'd1;
    localparam t_sym SYM_OPT  = 2'd2;
    localparam t_sym SYM_EXPR = 2'd3;
    localparam t_sym SYM_PAD  = 2'd0;

    typedef logic [2:0] t_tok;
    localparam t_tok TOK_OPEN    = 3'd0;
    localparam t_tok TOK_CLOSE   = 3'd1;
    localparam t_tok TOK_ANDOR   = 3'd2;
    localparam t_tok TOK_COMPARE = 3'd3;
    localparam t_tok TOK_LIKE    = 3'd4;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NO_OPEN      = 4'd1,
        ST_BEFORE_CLOSE = 4'd2,
        ST_OPERATOR     = 4'd3,
        ST_LEFT         = 4'd4,
        ST_RIGHT        = 4'd5,
        ST_LIKE_LEFT    = 4'd6,
        ST_LIKE_RIGHT   = 4'd7,
        ST_TOKEN        = 4'd8,
        ST_MISSING      = 4'd9,
        ST_OVERFLOW     = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_CLOSE = 3'd1,
        OP_ANDOR = 3'd2,
        OP_FOLD  = 3'd3,
        OP_FAIL  = 3'd4
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_status err;
        logic    last;
    } t_cmd;

endpackage

// ===== src/fcsc_front.sv =====
// token intake and classification into stack commands
module fcsc_front
    import fcsc_pkg::*;
(
    input  logic       i_valid,
    input  logic [2:0] i_token_kind,
    input  logic       i_is_string_compare,
    input  logic       i_left_side_valid,
    input  logic       i_right_side_valid,
    input  logic       i_like_left_is_field,
    input  logic       i_like_right_is_string,
    input  logic       i_last_token,
    input  logic       i_queue_full,
    output logic       o_ready,
    output logic       o_wr,
    output t_cmd       o_cmd
);

    assign o_ready = !i_queue_full;
    assign o_wr    = i_valid && !i_queue_full;

    always_comb begin
        o_cmd.op   = OP_FAIL;
        o_cmd.err  = ST_TOKEN;
        o_cmd.last = i_last_token;
        case (i_token_kind)
            TOK_OPEN: begin
                o_cmd.op  = OP_OPEN;
                o_cmd.err = ST_OK;
            end
            TOK_CLOSE: begin
                o_cmd.op  = OP_CLOSE;
                o_cmd.err = ST_OK;
            end
            TOK_ANDOR: begin
                o_cmd.op  = OP_ANDOR;
                o_cmd.err = ST_OK;
            end
            TOK_COMPARE: begin
                if (!i_is_string_compare && !i_left_side_valid) begin
                    o_cmd.err = ST_LEFT;
                end else if (!i_is_string_compare && !i_right_side_valid) begin
                    o_cmd.err = ST_RIGHT;
                end else begin
                    o_cmd.op  = OP_FOLD;
                    o_cmd.err = ST_OK;
                end
            end
            TOK_LIKE: begin
                if (!i_like_left_is_field) begin
                    o_cmd.err = ST_LIKE_LEFT;
                end else if (!i_like_right_is_string) begin
                    o_cmd.err = ST_LIKE_RIGHT;
                end else begin
                    o_cmd.op  = OP_FOLD;
                    o_cmd.err = ST_OK;
                end
            end
            default: begin
                o_cmd.op  = OP_FAIL;
                o_cmd.err = ST_TOKEN;
            end
        endcase
    end

endmodule

// ===== src/fcsc_queue.sv =====
// short command queue between classification and stack engine
`include "assert_macros.svh"
module fcsc_queue
    import fcsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_cmd  i_cmd,
    input  logic  i_rd,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    `ASSERT_ALWAYS(a_q_count_range, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `ASSERT_IMPL(a_q_no_wr_full, i_clk, i_rst_n, i_wr, !o_full, "queue written while full")
    `ASSERT_IMPL(a_q_no_rd_empty, i_clk, i_rst_n, i_rd, o_valid, "queue read while empty")

endmodule

// ===== src/fcsc_back.sv =====
// symbol stack engine with error latch and status output register
`include "assert_macros.svh"
module fcsc_back
    import fcsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_status o_status
);

    t_sym             r_stack [STACK_DEPTH];
    logic [LVL_W-1:0] r_level;
    t_status          r_err;
    logic             r_out_valid;
    t_status          r_status;

    t_sym             n_stack [STACK_DEPTH];
    logic [LVL_W-1:0] n_level;
    t_status          n_err;
    logic             n_out_valid;
    t_status          n_status;

    t_sym             w_ext [STACK_DEPTH + 4];
    t_sym             w_up  [STACK_DEPTH];
    logic [2:0]       w_pops;
    logic             w_push;
    t_sym             w_push_val;
    t_status          w_tok_err;
    logic             w_take;
    logic             w_fold4;

    assign w_take      = i_cmd_valid && (!i_cmd.last || !r_out_valid || i_out_ready);
    assign o_cmd_take  = w_take;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // "expr op" sitting right under the top pair
    assign w_fold4 = (r_level > LVL_W'(3)) && (r_stack[2] == SYM_OPT)
                     && (r_stack[3] == SYM_EXPR);

    always_comb begin
        w_pops     = 3'd0;
        w_push     = 1'b0;
        w_push_val = SYM_EXPR;
        w_tok_err  = ST_OK;
        case (i_cmd.op)
            OP_OPEN: begin
                w_push     = 1'b1;
                w_push_val = SYM_LEFT;
            end
            OP_CLOSE: begin
                if (r_level < LVL_W'(2)) begin
                    w_tok_err = ST_NO_OPEN;
                end else if (r_stack[0] != SYM_EXPR || r_stack[1] != SYM_LEFT) begin
                    w_tok_err = ST_BEFORE_CLOSE;
                end else begin
                    w_pops = w_fold4 ? 3'd4 : 3'd2;
                    w_push = 1'b1;
                end
            end
            OP_ANDOR: begin
                if (r_level == '0 || r_stack[0] != SYM_EXPR) begin
                    w_tok_err = ST_OPERATOR;
                end else begin
                    w_push     = 1'b1;
                    w_push_val = SYM_OPT;
                end
            end
            OP_FOLD: begin
                w_push = 1'b1;
                if (r_level != '0 && r_stack[0] == SYM_OPT) begin
                    if (r_level == LVL_W'(1)) begin
                        w_pops = 3'd1;
                    end else begin
                        w_pops = w_fold4 ? 3'd4 : 3'd2;
                    end
                end
            end
            OP_FAIL: begin
                w_tok_err = i_cmd.err;
            end
            default: begin
                w_tok_err = ST_TOKEN;
            end
        endcase
        if (w_push && w_pops == 3'd0 && r_level == LVL_W'(STACK_DEPTH)) begin
            w_push    = 1'b0;
            w_tok_err = ST_OVERFLOW;
        end
    end

    always_comb begin
        for (int i = 0; i < STACK_DEPTH + 4; i++) begin
            w_ext[i] = (i < STACK_DEPTH) ? r_stack[i % STACK_DEPTH] : SYM_PAD;
        end
        for (int i = 0; i < STACK_DEPTH; i++) begin
            case (w_pops)
                3'd1:    w_up[i] = w_ext[i + 1];
                3'd2:    w_up[i] = w_ext[i + 2];
                3'd4:    w_up[i] = w_ext[i + 4];
                default: w_up[i] = w_ext[i];
            endcase
        end
    end

    always_comb begin
        n_level     = r_level;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            n_stack[i] = r_stack[i];
        end
        if (w_take && r_err == ST_OK) begin
            n_err   = w_tok_err;
            n_level = r_level - LVL_W'(w_pops) + LVL_W'(w_push);
            if (w_tok_err == ST_OK) begin
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    if (w_push) begin
                        n_stack[i] = (i == 0) ? w_push_val : w_up[(i + STACK_DEPTH - 1) % STACK_DEPTH];
                    end else begin
                        n_stack[i] = w_up[i];
                    end
                end
            end
        end
        if (w_take && i_cmd.last) begin
            n_out_valid = 1'b1;
            if (n_err != ST_OK) begin
                n_status = n_err;
            end else if (n_level == LVL_W'(1) && n_stack[0] == SYM_EXPR) begin
                n_status = ST_OK;
            end else begin
                n_status = ST_MISSING;
            end
            n_level = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            r_stack[i] <= n_stack[i];
        end
    end

    `ASSERT_ALWAYS(a_bk_level_range, i_clk, i_rst_n, r_level <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
    `ASSERT_NEXT(a_bk_clear_on_last, i_clk, i_rst_n, w_take && i_cmd.last, r_level == '0 && r_err == ST_OK && r_out_valid, "clause state not cleared after last token")
    `ASSERT_NEXT(a_bk_err_held, i_clk, i_rst_n, r_err != ST_OK && !(w_take && i_cmd.last), r_err == $past(r_err), "latched error changed before last token")

endmodule

// ===== src/filter_clause_syntax_checker.sv =====
// filter clause syntax checker: intake, command queue and symbol stack engine
// a last token is queued, then the stack engine registers its status for output
// throughput: one token per cycle while the command queue is not full
// a two-entry command queue lets intake run on while the status waits to be taken
// reset (synchronous, active low) empties the queue, the stack level and the error latch
module filter_clause_syntax_checker
    import fcsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // is_string_compare, left_side_valid, right_side_valid,
                                      // like_left_is_field, like_right_is_string, zero pad
    input  logic [2:0] s_axis_tuser,  // token_kind
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // status_code, zero pad
);

    logic    w_full;
    logic    w_wr;
    t_cmd    w_wr_cmd;
    logic    w_q_valid;
    t_cmd    w_q_cmd;
    logic    w_take;
    t_status w_status;

    fcsc_front u_front (
        .i_valid                (s_axis_tvalid),
        .i_token_kind           (s_axis_tuser),
        .i_is_string_compare    (s_axis_tdata[0]),
        .i_left_side_valid      (s_axis_tdata[1]),
        .i_right_side_valid     (s_axis_tdata[2]),
        .i_like_left_is_field   (s_axis_tdata[3]),
        .i_like_right_is_string (s_axis_tdata[4]),
        .i_last_token           (s_axis_tlast),
        .i_queue_full           (w_full),
        .o_ready                (s_axis_tready),
        .o_wr                   (w_wr),
        .o_cmd                  (w_wr_cmd)
    );

    fcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_wr_cmd),
        .i_rd    (w_take),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    fcsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_take  (w_take),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status)
    );

    assign m_axis_tdata = {4'b0000, w_status};

endmodule
